// ===== design/hsn_pkg.sv =====
`default_nettype none

package hsn_pkg;

   // Command codes of the request channel.
   localparam logic [1:0] CMD_VISIT   = 2'd0;
   localparam logic [1:0] CMD_BACK    = 2'd1;
   localparam logic [1:0] CMD_FORWARD = 2'd2;

   // Commands from the controller to the datapath, valid for one cycle.
   typedef struct packed {
      logic visit;        // push current (unless empty page), load new page
      logic ignore;       // report an ignored step
      logic nav_back;     // push current forward, start the back stack read
      logic nav_fwd;      // push current back, start the forward stack read
      logic load_back;    // take the back stack read data as current
      logic load_fwd;     // take the forward stack read data as current
   } hsn_dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic back_empty;
      logic fwd_empty;
   } hsn_dp_status_type;

endpackage

`default_nettype wire

// ===== design/hsn_ram.sv =====
`default_nettype none

module hsn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/hsn_ctrl.sv =====
`default_nettype none

module hsn_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [1:0]                 req_command,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output hsn_pkg::hsn_dp_cmd_type         dp_cmd,
   input  wire hsn_pkg::hsn_dp_status_type dp_status
);

   import hsn_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP_BACK,
      ST_POP_FWD
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;
   logic      accept;
   logic      finish;

   // The result register is free when empty or when its transfer completes now.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      dp_cmd   = '0;
      state_in = state_ff;
      finish   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_VISIT: begin
                     dp_cmd.visit = 1'b1;
                     finish       = 1'b1;
                  end
                  CMD_BACK: begin
                     if (dp_status.back_empty) begin
                        dp_cmd.ignore = 1'b1;
                        finish        = 1'b1;
                     end else begin
                        dp_cmd.nav_back = 1'b1;
                        state_in        = ST_POP_BACK;
                     end
                  end
                  CMD_FORWARD: begin
                     if (dp_status.fwd_empty) begin
                        dp_cmd.ignore = 1'b1;
                        finish        = 1'b1;
                     end else begin
                        dp_cmd.nav_fwd = 1'b1;
                        state_in       = ST_POP_FWD;
                     end
                  end
                  default: begin
                     dp_cmd.ignore = 1'b1;
                     finish        = 1'b1;
                  end
               endcase
            end
         end
         // The result register was free when the read started and nothing
         // else fills it, so the pop can always complete here.
         ST_POP_BACK: begin
            dp_cmd.load_back = 1'b1;
            finish           = 1'b1;
            state_in         = ST_IDLE;
         end
         ST_POP_FWD: begin
            dp_cmd.load_fwd = 1'b1;
            finish          = 1'b1;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = finish || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== design/hsn_datapath.sv =====
`default_nettype none

module hsn_datapath #(
   parameter int STACK_DEPTH = 128,
   parameter int PAGE_BITS   = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [PAGE_BITS-1:0]    req_page_id,
   input  wire hsn_pkg::hsn_dp_cmd_type dp_cmd,
   output hsn_pkg::hsn_dp_status_type   dp_status,
   output logic      [PAGE_BITS-1:0]    rsp_shown_page,
   output logic                         rsp_ignored
);

   import hsn_pkg::*;

   localparam int ADDR_BITS  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(STACK_DEPTH + 1);
   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(STACK_DEPTH);
   localparam logic [COUNT_BITS-1:0] ONE_COUNT  = COUNT_BITS'(1);

   logic [PAGE_BITS-1:0]  current_ff;
   logic [PAGE_BITS-1:0]  current_in;
   logic [COUNT_BITS-1:0] back_count_ff;
   logic [COUNT_BITS-1:0] back_count_in;
   logic [COUNT_BITS-1:0] fwd_count_ff;
   logic [COUNT_BITS-1:0] fwd_count_in;
   logic [PAGE_BITS-1:0]  shown_ff;
   logic [PAGE_BITS-1:0]  shown_in;
   logic                  ignored_ff;
   logic                  ignored_in;

   logic                  back_full;
   logic                  fwd_full;
   logic                  back_wr_en;
   logic                  fwd_wr_en;
   logic [COUNT_BITS-1:0] back_top;
   logic [COUNT_BITS-1:0] fwd_top;
   logic [PAGE_BITS-1:0]  back_rd_data;
   logic [PAGE_BITS-1:0]  fwd_rd_data;

   assign back_full = (back_count_ff == FULL_COUNT);
   assign fwd_full  = (fwd_count_ff == FULL_COUNT);
   assign back_top  = back_count_ff - ONE_COUNT;
   assign fwd_top   = fwd_count_ff - ONE_COUNT;

   assign dp_status.back_empty = (back_count_ff == '0);
   assign dp_status.fwd_empty  = (fwd_count_ff == '0);

   // A push onto a full stack is dropped; visit never pushes the empty page.
   assign back_wr_en = !back_full &&
                       ((dp_cmd.visit && (current_ff != '0)) || dp_cmd.nav_fwd);
   assign fwd_wr_en  = !fwd_full && dp_cmd.nav_back;

   hsn_ram #(
      .WIDTH (PAGE_BITS),
      .DEPTH (STACK_DEPTH)
   ) u_back_ram (
      .clock   (clock),
      .wr_en   (back_wr_en),
      .wr_addr (back_count_ff[ADDR_BITS-1:0]),
      .wr_data (current_ff),
      .rd_en   (dp_cmd.nav_back),
      .rd_addr (back_top[ADDR_BITS-1:0]),
      .rd_data (back_rd_data)
   );

   hsn_ram #(
      .WIDTH (PAGE_BITS),
      .DEPTH (STACK_DEPTH)
   ) u_fwd_ram (
      .clock   (clock),
      .wr_en   (fwd_wr_en),
      .wr_addr (fwd_count_ff[ADDR_BITS-1:0]),
      .wr_data (current_ff),
      .rd_en   (dp_cmd.nav_fwd),
      .rd_addr (fwd_top[ADDR_BITS-1:0]),
      .rd_data (fwd_rd_data)
   );

   always_comb begin
      current_in    = current_ff;
      back_count_in = back_count_ff;
      fwd_count_in  = fwd_count_ff;
      shown_in      = shown_ff;
      ignored_in    = ignored_ff;

      if (back_wr_en) begin
         back_count_in = back_count_ff + ONE_COUNT;
      end
      if (fwd_wr_en) begin
         fwd_count_in = fwd_count_ff + ONE_COUNT;
      end

      if (dp_cmd.visit) begin
         current_in   = req_page_id;
         fwd_count_in = '0;
         shown_in     = req_page_id;
         ignored_in   = 1'b0;
      end
      if (dp_cmd.ignore) begin
         shown_in   = '0;
         ignored_in = 1'b1;
      end
      if (dp_cmd.nav_back) begin
         back_count_in = back_top;
      end
      if (dp_cmd.nav_fwd) begin
         fwd_count_in = fwd_top;
      end
      if (dp_cmd.load_back) begin
         current_in = back_rd_data;
         shown_in   = back_rd_data;
         ignored_in = 1'b0;
      end
      if (dp_cmd.load_fwd) begin
         current_in = fwd_rd_data;
         shown_in   = fwd_rd_data;
         ignored_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff    <= '0;
         back_count_ff <= '0;
         fwd_count_ff  <= '0;
      end else begin
         current_ff    <= current_in;
         back_count_ff <= back_count_in;
         fwd_count_ff  <= fwd_count_in;
      end
   end

   always_ff @(posedge clock) begin
      shown_ff   <= shown_in;
      ignored_ff <= ignored_in;
   end

   assign rsp_shown_page = shown_ff;
   assign rsp_ignored    = ignored_ff;

endmodule

`default_nettype wire

// ===== design/two_stack_history_navigator_top.sv =====
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  req_command, req_page_id
// rsp_      out        rsp_valid / rsp_stall  rsp_shown_page, rsp_ignored
//
// A visit, or a back or forward step that finds its stack empty, is handled in the idle state alone.
// A back or forward step passes through a pop state: the stack read is issued with the push
// onto the other stack, and the registered read data becomes current in the next cycle.
// Reset clears the current page and both stack counts; the stack memories are not cleared.
// Requests are stalled while a step is in progress and while a finished result
// is held by a stalled response channel.

module two_stack_history_navigator_top #(
   parameter int STACK_DEPTH = 128,
   parameter int PAGE_BITS   = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_command,
   input  wire logic [PAGE_BITS-1:0] req_page_id,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic      [PAGE_BITS-1:0] rsp_shown_page,
   output logic                      rsp_ignored
);

   import hsn_pkg::*;

   hsn_dp_cmd_type    dp_cmd;
   hsn_dp_status_type dp_status;

   hsn_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .dp_cmd      (dp_cmd),
      .dp_status   (dp_status)
   );

   hsn_datapath #(
      .STACK_DEPTH (STACK_DEPTH),
      .PAGE_BITS   (PAGE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_page_id    (req_page_id),
      .dp_cmd         (dp_cmd),
      .dp_status      (dp_status),
      .rsp_shown_page (rsp_shown_page),
      .rsp_ignored    (rsp_ignored)
   );

endmodule

`default_nettype wire

// ===== dv/tb_two_stack_history_navigator_top.sv =====
`default_nettype none

module tb_two_stack_history_navigator_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hsn_pkg::*;

   localparam int STACK_DEPTH = 128;
   localparam int PAGE_BITS   = 16;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS    = 1800;
   localparam int LONG_HOLD       = 250;
   localparam int DRAIN_LIMIT     = 5000;
   localparam int RUN_LIMIT_NS    = 15_000_000;

   typedef logic [PAGE_BITS-1:0] page_type;

   typedef struct packed {
      page_type shown_page;
      logic     ignored;
   } nav_view_type;

   // One row of the directed plan; fixed_view is used only where is_fixed is set.
   typedef struct {
      logic [1:0]   command;
      page_type     page_id;
      bit           is_fixed;
      nav_view_type fixed_view;
   } nav_row_type;

   typedef struct {
      bit           is_fixed;
      nav_view_type fixed_view;
   } offer_tag_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [1:0] req_command;
   page_type req_page_id;
   logic rsp_valid;
   logic rsp_stall;
   page_type rsp_shown_page;
   logic rsp_ignored;

   // Model of the history: two bounded stacks and the current page.
   page_type back_mem [STACK_DEPTH];
   page_type fwd_mem [STACK_DEPTH];
   int       back_n;
   int       fwd_n;
   page_type cur_page;

   offer_tag_type offered_tags [$];
   nav_view_type  expected_views [$];
   int mismatch_count = 0;
   int shown_count = 0;
   int items_sent = 0;

   localparam int PLAN_ROWS = 24;
   nav_row_type plan [PLAN_ROWS] = '{
      '{CMD_BACK,    16'h0000, 1'b1, '{16'h0000, 1'b1}},
      '{CMD_FORWARD, 16'hFFFF, 1'b1, '{16'h0000, 1'b1}},
      '{CMD_UNUSED,  16'h1234, 1'b1, '{16'h0000, 1'b1}},
      '{CMD_VISIT,   16'h0000, 1'b1, '{16'h0000, 1'b0}},
      '{CMD_BACK,    16'h0000, 1'b1, '{16'h0000, 1'b1}},
      '{CMD_VISIT,   16'hFFFF, 1'b1, '{16'hFFFF, 1'b0}},
      '{CMD_VISIT,   16'h0001, 1'b1, '{16'h0001, 1'b0}},
      '{CMD_BACK,    16'hFFFF, 1'b0, '{16'h0000, 1'b0}},
      '{CMD_FORWARD, 16'h0000, 1'b0, '{16'h0000, 1'b0}},
      '{CMD_FORWARD, 16'hFFFF, 1'b1, '{16'h0000, 1'b1}},
      '{CMD_BACK,    16'h0000, 1'b0, '{16'h0000, 1'b0}},
      '{CMD_VISIT,   16'h8000, 1'b1, '{16'h8000, 1'b0}},
      '{CMD_FORWARD, 16'h7FFF, 1'b1, '{16'h0000, 1'b1}},
      '{CMD_VISIT,   16'h0000, 1'b1, '{16'h0000, 1'b0}},
      '{CMD_BACK,    16'h0000, 1'b0, '{16'h0000, 1'b0}},
      '{CMD_FORWARD, 16'h0000, 1'b0, '{16'h0000, 1'b0}},
      '{CMD_BACK,    16'h0000, 1'b0, '{16'h0000, 1'b0}},
      '{CMD_BACK,    16'h0000, 1'b0, '{16'h0000, 1'b0}},
      '{CMD_BACK,    16'h0000, 1'b1, '{16'h0000, 1'b1}},
      '{CMD_FORWARD, 16'h0000, 1'b0, '{16'h0000, 1'b0}},
      '{CMD_FORWARD, 16'h0000, 1'b0, '{16'h0000, 1'b0}},
      '{CMD_UNUSED,  16'h0000, 1'b1, '{16'h0000, 1'b1}},
      '{CMD_VISIT,   16'h5A5A, 1'b1, '{16'h5A5A, 1'b0}},
      '{CMD_BACK,    16'hA5A5, 1'b0, '{16'h0000, 1'b0}}
   };

   two_stack_history_navigator_top #(
      .STACK_DEPTH(STACK_DEPTH),
      .PAGE_BITS  (PAGE_BITS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_page_id   (req_page_id),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_shown_page(rsp_shown_page),
      .rsp_ignored   (rsp_ignored)
   );

   always #5 clock = ~clock;

   // Advances the history model by one command and returns the view it shows.
   function automatic nav_view_type navigate(logic [1:0] command, page_type page_id);
      nav_view_type view;
      view = '0;
      case (command)
         CMD_VISIT: begin
            if (cur_page != '0 && back_n < STACK_DEPTH) begin
               back_mem[back_n] = cur_page;
               back_n++;
            end
            cur_page = page_id;
            fwd_n = 0;
         end
         CMD_BACK: begin
            if (back_n == 0) begin
               view.ignored = 1'b1;
            end else begin
               if (fwd_n < STACK_DEPTH) begin
                  fwd_mem[fwd_n] = cur_page;
                  fwd_n++;
               end
               back_n--;
               cur_page = back_mem[back_n];
            end
         end
         CMD_FORWARD: begin
            if (fwd_n == 0) begin
               view.ignored = 1'b1;
            end else begin
               if (back_n < STACK_DEPTH) begin
                  back_mem[back_n] = cur_page;
                  back_n++;
               end
               fwd_n--;
               cur_page = fwd_mem[fwd_n];
            end
         end
         default: begin
            view.ignored = 1'b1;
         end
      endcase
      if (!view.ignored) begin
         view.shown_page = cur_page;
      end
      return view;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic page_type pick_page();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) return '0;
      if (roll < 12) return '1;
      return page_type'($urandom);
   endfunction

   // Offers one command and returns at the clock edge on which it is taken.
   task automatic send_item(logic [1:0] command, page_type page_id, bit is_fixed,
                            nav_view_type fixed_view);
      int gap;
      offer_tag_type tag;
      gap = pick_gap();
      // Every fourth stretch of 150 items goes without idling.
      if ((items_sent / 150) % 4 == 1) begin
         gap = 0;
      end
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_command <= 2'($urandom);
         req_page_id <= page_type'($urandom);
      end
      tag.is_fixed = is_fixed;
      tag.fixed_view = fixed_view;
      offered_tags.push_back(tag);
      @(negedge clock);
      req_valid <= 1'b1;
      req_command <= command;
      req_page_id <= page_id;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_random(logic [1:0] command);
      send_item(command, pick_page(), 1'b0, '0);
   endtask

   task automatic run_random();
      int kind;
      int count;
      while (items_sent < PLAN_ROWS + RANDOM_ITEMS) begin
         kind = $urandom_range(0, 19);
         if (kind == 0) begin
            // Overfill the back stack, then walk back, at times past its bottom, and forward again.
            repeat ($urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 12)) send_random(CMD_VISIT);
            repeat ($urandom_range(100, STACK_DEPTH + 8)) send_random(CMD_BACK);
            repeat ($urandom_range(0, 40)) send_random(CMD_FORWARD);
         end else if (kind <= 14) begin
            repeat ($urandom_range(1, 8)) send_random(CMD_VISIT);
            count = $urandom_range(1, 12);
            repeat (count) begin
               send_random(($urandom_range(0, 9) < 6) ? CMD_BACK : CMD_FORWARD);
            end
         end else if (kind <= 17) begin
            repeat ($urandom_range(1, 10)) send_random(2'($urandom));
         end else begin
            repeat ($urandom_range(1, 10)) send_random(CMD_BACK);
            repeat ($urandom_range(1, 10)) send_random(CMD_FORWARD);
         end
      end
   endtask

   always @(posedge clock) begin : scoreboard
      offer_tag_type tag;
      nav_view_type predicted;
      nav_view_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            tag = offered_tags.pop_front();
            predicted = navigate(req_command, req_page_id);
            expected_views.push_back(tag.is_fixed ? tag.fixed_view : predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            shown_count++;
            if (expected_views.size() == 0) begin
               $error("unexpected transfer: shown_page %h ignored %b",
                      rsp_shown_page, rsp_ignored);
               mismatch_count++;
            end else begin
               want = expected_views.pop_front();
               if (rsp_shown_page !== want.shown_page) begin
                  $error("shown_page: expected %h, got %h", want.shown_page, rsp_shown_page);
                  mismatch_count++;
               end
               if (rsp_ignored !== want.ignored) begin
                  $error("ignored: expected %b, got %b", want.ignored, rsp_ignored);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Receiver: random stalls, long stall-free runs, and two long hold-offs that
   // let the block fill up and push back on its input.
   initial begin : receiver
      int stall_len;
      int run_len;
      int holds_done;
      holds_done = 0;
      rsp_stall = 1'b0;
      forever begin
         if (holds_done < 2 && shown_count >= 300 + 800 * holds_done) begin
            holds_done++;
            stall_len = LONG_HOLD;
         end else begin
            stall_len = pick_gap();
         end
         repeat (stall_len) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 8);
         repeat (run_len) begin
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      int drain;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_VISIT;
      req_page_id = '0;
      back_n = 0;
      fwd_n = 0;
      cur_page = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         send_item(plan[i].command, plan[i].page_id, plan[i].is_fixed, plan[i].fixed_view);
      end
      run_random();

      @(negedge clock);
      req_valid <= 1'b0;
      drain = 0;
      while (expected_views.size() != 0 && drain < DRAIN_LIMIT) begin
         @(negedge clock);
         drain++;
      end
      repeat (4) @(negedge clock);
      if (expected_views.size() != 0) begin
         $error("%0d expected transfers never arrived", expected_views.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
